FILE: sv/assert_macros.svh
// assertion helper macros used by the datapath (wbtsc_dp)
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/wbtsc_pkg.sv
// shared types, constants and key function of the write batch trimmer
// no dependencies
package wbtsc_pkg;

  localparam int MAX_OPS = 32;
  localparam int AW      = $clog2(MAX_OPS);
  localparam int CW      = $clog2(MAX_OPS + 1);
  localparam int KEY_W   = 4 + 49 + AW;

  // register indexes of the configuration port
  localparam logic [1:0] REG_WRITE_CODE = 2'd0;
  localparam logic [1:0] REG_TRUNC_CODE = 2'd1;

  typedef struct packed {
    logic [3:0]  kind;
    logic        has_id;
    logic [31:0] op_id;
    logic [47:0] offset;
    logic [31:0] length;
    logic [47:0] new_size;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_run;
    logic clip;
    logic trim;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic last_round;
  } status_t;

  // total order: kind, then offset for writes or id (id-less last), then arrival
  function automatic logic [KEY_W-1:0] sort_key(entry_t e, logic [AW-1:0] idx,
                                                logic [3:0] wcode);
    logic [48:0] sub;
    if (e.kind == wcode) begin
      sub = {1'b0, e.offset};
    end else begin
      sub = {16'd0, ~e.has_id, (e.has_id ? e.op_id : 32'd0)};
    end
    return {e.kind, sub, idx};
  endfunction

endpackage

FILE: sv/wbtsc_ctrl.sv
// controller state machine: load, per-round selection scan, clip, trim, flush
// depends on wbtsc_pkg
module wbtsc_ctrl import wbtsc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_last,
  input  status_t st,
  output cmd_t    cmd,
  output logic    busy
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CLIP  = 3'd2;
  localparam logic [2:0] S_TRIM  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign busy   = (state_r != S_LOAD);
  assign accept = start && !busy;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        cmd.load = accept;
        if (accept && in_last) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (st.scan_done) state_nxt = S_CLIP;
      end
      S_CLIP: begin
        cmd.clip  = 1'b1;
        state_nxt = S_TRIM;
      end
      S_TRIM: begin
        cmd.trim = 1'b1;
        if (st.last_round) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else        state_r <= state_nxt;
  end

endmodule

FILE: sv/wbtsc_dp.sv
// datapath: batch store, selection scan, clip and overlap trim, output registers
// depends on wbtsc_pkg and assert_macros.svh
`include "assert_macros.svh"
module wbtsc_dp import wbtsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata,
  input  logic [3:0]  in_kind,
  input  logic [31:0] in_op_id,
  input  logic        in_has_id,
  input  logic [47:0] in_offset,
  input  logic [31:0] in_length,
  input  logic [47:0] in_new_size,
  output logic        out_strobe,
  output logic [3:0]  out_kind,
  output logic [31:0] out_id,
  output logic        out_has_id,
  output logic [47:0] out_offset,
  output logic [31:0] out_length,
  output logic [47:0] out_new_size,
  output logic        out_last,
  output logic        out_valid,
  output logic        out_overflow
);

  entry_t mem [MAX_OPS];
  entry_t rd_data_r;
  entry_t in_e;

  logic [3:0]       wcode_r, tcode_r;
  logic [CW-1:0]    count_r, scan_idx_r, round_r;
  logic             trunc_seen_r, ovf_r;
  logic [AW-1:0]    ltp_r, rd_idx_r, best_idx_r;
  logic [47:0]      tsize_r;
  logic             rd_vld_r, best_found_r, has_prev_r;
  logic [KEY_W-1:0] best_key_r, prev_key_r, rd_key;
  entry_t           best_r, clip_r, pend_r;
  logic             clip_alive_r, pend_vld_r;
  logic [48:0]      maxoff_r;

  // clip and trim arithmetic
  logic [48:0] c_end, t_end;
  logic        c_write, t_write, rd_better;

  assign in_e = '{kind: in_kind, has_id: in_has_id, op_id: in_op_id,
                  offset: in_offset, length: in_length, new_size: in_new_size};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcode_r <= 4'd0;
      tcode_r <= 4'd1;
    end else if (cfg_we) begin
      if (cfg_index == REG_WRITE_CODE) wcode_r <= cfg_wdata;
      if (cfg_index == REG_TRUNC_CODE) tcode_r <= cfg_wdata;
    end
  end

  // batch store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.load && count_r < CW'(MAX_OPS)) mem[count_r[AW-1:0]] <= in_e;
    rd_data_r <= mem[scan_idx_r[AW-1:0]];
  end

  // selection compare
  assign rd_key    = sort_key(rd_data_r, rd_idx_r, wcode_r);
  assign rd_better = (!has_prev_r || rd_key > prev_key_r) &&
                     (!best_found_r || rd_key < best_key_r);

  assign st.scan_done  = rd_vld_r && (CW'(rd_idx_r) == count_r - CW'(1));
  assign st.last_round = (round_r == count_r - CW'(1));

  assign c_write = (best_r.kind == wcode_r);
  assign c_end   = {1'b0, best_r.offset} + {17'd0, best_r.length};
  assign t_write = (clip_r.kind == wcode_r);
  assign t_end   = {1'b0, clip_r.offset} + {17'd0, clip_r.length};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      trunc_seen_r <= 1'b0;
      ovf_r        <= 1'b0;
      scan_idx_r   <= '0;
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      has_prev_r   <= 1'b0;
      round_r      <= '0;
      pend_vld_r   <= 1'b0;
      maxoff_r     <= '0;
      out_strobe   <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      // load one item
      if (cmd.load) begin
        if (count_r < CW'(MAX_OPS)) begin
          if (in_kind == tcode_r) trunc_seen_r <= 1'b1;
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      // round start
      if (cmd.scan_init) begin
        scan_idx_r   <= '0;
        rd_vld_r     <= 1'b0;
        best_found_r <= 1'b0;
      end
      // address walk and compare
      if (cmd.scan_run) begin
        rd_vld_r <= (scan_idx_r < count_r);
        if (scan_idx_r < count_r) scan_idx_r <= scan_idx_r + CW'(1);
        if (rd_vld_r && rd_better) best_found_r <= 1'b1;
      end
      // overlap trim and hand-off through the pending slot
      if (cmd.trim) begin
        has_prev_r <= 1'b1;
        round_r    <= round_r + CW'(1);
        if (clip_alive_r && !(t_write && t_end <= maxoff_r)) begin
          pend_vld_r <= 1'b1;
          if (pend_vld_r) out_strobe <= 1'b1;
          if (t_write) maxoff_r <= t_end;
        end
      end
      // final result, then clear the batch
      if (cmd.flush) begin
        out_strobe   <= 1'b1;
        count_r      <= '0;
        trunc_seen_r <= 1'b0;
        ovf_r        <= 1'b0;
        has_prev_r   <= 1'b0;
        round_r      <= '0;
        pend_vld_r   <= 1'b0;
        maxoff_r     <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load && count_r < CW'(MAX_OPS) && in_kind == tcode_r) begin
      ltp_r   <= count_r[AW-1:0];
      tsize_r <= in_new_size;
    end
    if (cmd.scan_run) rd_idx_r <= scan_idx_r[AW-1:0];
    if (cmd.scan_run && rd_vld_r && rd_better) begin
      best_key_r <= rd_key;
      best_r     <= rd_data_r;
      best_idx_r <= rd_idx_r;
    end
    // clip writes up to the last truncate
    if (cmd.clip) begin
      clip_r       <= best_r;
      clip_alive_r <= 1'b1;
      if (trunc_seen_r && best_idx_r <= ltp_r && c_write && c_end > {1'b0, tsize_r}) begin
        if (best_r.offset >= tsize_r) clip_alive_r <= 1'b0;
        else clip_r.length <= 32'(tsize_r - best_r.offset);
      end
    end
    if (cmd.trim) begin
      prev_key_r <= best_key_r;
      if (clip_alive_r && !(t_write && t_end <= maxoff_r)) begin
        pend_r <= clip_r;
        if (t_write && {1'b0, clip_r.offset} < maxoff_r) begin
          pend_r.offset <= maxoff_r[47:0];
          pend_r.length <= 32'(t_end - maxoff_r);
        end
      end
    end
    // output register
    if (cmd.trim && pend_vld_r) begin
      out_kind     <= pend_r.kind;
      out_id       <= pend_r.op_id;
      out_has_id   <= pend_r.has_id;
      out_offset   <= pend_r.offset;
      out_length   <= pend_r.length;
      out_new_size <= pend_r.new_size;
      out_last     <= 1'b0;
      out_valid    <= 1'b1;
      out_overflow <= ovf_r;
    end
    if (cmd.flush) begin
      out_kind     <= pend_vld_r ? pend_r.kind : 4'd0;
      out_id       <= pend_vld_r ? pend_r.op_id : 32'd0;
      out_has_id   <= pend_vld_r && pend_r.has_id;
      out_offset   <= pend_vld_r ? pend_r.offset : 48'd0;
      out_length   <= pend_vld_r ? pend_r.length : 32'd0;
      out_new_size <= pend_vld_r ? pend_r.new_size : 48'd0;
      out_last     <= 1'b1;
      out_valid    <= pend_vld_r;
      out_overflow <= ovf_r;
    end
  end

  // checks
  `ASSERT_ALWAYS(a_count_cap, count_r <= CW'(MAX_OPS), "item count beyond capacity")
  `ASSERT_NEXT(a_flush_clears, cmd.flush, count_r == '0 && !pend_vld_r, "batch not cleared")
  `ASSERT_IMPLY(a_trim_round, cmd.trim, best_found_r, "trim without a selected entry")

endmodule

FILE: sv/write_batch_trim_sort_coalesce_core.sv
// top level of the write batch trimmer: controller plus datapath
// depends on wbtsc_pkg, wbtsc_ctrl and wbtsc_dp
//
// channel   handshake              payload
// input     start / busy           in_kind in_op_id in_has_id in_offset in_length
//                                  in_new_size in_last
// result    out_strobe (1 cycle)   out_kind out_id out_has_id out_offset out_length
//                                  out_new_size out_last out_valid out_overflow
// config    cfg_we                 cfg_index cfg_wdata
//
// loading takes one item per cycle while busy is low
// after the last item, one scan of the batch store per stored item selects the next
// entry in sort order, followed by one clip step and one trim step, and a flush
// step then gives the final result
// busy is high from the last item until the final result strobe
// reset clears the batch and sets the write and truncate codes to 0 and 1; results cannot be held off
module write_batch_trim_sort_coalesce_core import wbtsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata,
  input  logic [3:0]  in_kind,
  input  logic [31:0] in_op_id,
  input  logic        in_has_id,
  input  logic [47:0] in_offset,
  input  logic [31:0] in_length,
  input  logic [47:0] in_new_size,
  input  logic        in_last,
  output logic        out_strobe,
  output logic [3:0]  out_kind,
  output logic [31:0] out_id,
  output logic        out_has_id,
  output logic [47:0] out_offset,
  output logic [31:0] out_length,
  output logic [47:0] out_new_size,
  output logic        out_last,
  output logic        out_valid,
  output logic        out_overflow
);

  cmd_t    cmd;
  status_t st;

  wbtsc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_last),
    .st      (st),
    .cmd     (cmd),
    .busy    (busy)
  );

  wbtsc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_kind      (in_kind),
    .in_op_id     (in_op_id),
    .in_has_id    (in_has_id),
    .in_offset    (in_offset),
    .in_length    (in_length),
    .in_new_size  (in_new_size),
    .out_strobe   (out_strobe),
    .out_kind     (out_kind),
    .out_id       (out_id),
    .out_has_id   (out_has_id),
    .out_offset   (out_offset),
    .out_length   (out_length),
    .out_new_size (out_new_size),
    .out_last     (out_last),
    .out_valid    (out_valid),
    .out_overflow (out_overflow)
  );

endmodule
